@@ rtl/core/consistent_hash_ring_table_macros.svh @@
// ----------------------------------------------------------------------------
// Consistent hash ring table assertion macros
// Shared concurrent assertion shorthands for the ring table checkers.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_TABLE_MACROS_SVH
`define CONSISTENT_HASH_RING_TABLE_MACROS_SVH

// same-cycle implication, off while reset is high
`define CHRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chrt check failed");

// next-cycle implication, off while reset is high
`define CHRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chrt check failed");

// next-cycle implication that also runs through reset
`define CHRT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("chrt check failed");

`endif

@@ rtl/core/chrt_pkg.sv @@
// ----------------------------------------------------------------------------
// Consistent hash ring table package
// Sizes, item layouts and codes shared by the ring table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package chrt_pkg;

   // table geometry (depth 2..4096, node id bits 1..8)
   localparam int TABLE_DEPTH  = 64;
   localparam int NODE_ID_BITS = 8;
   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);

   // item field widths
   localparam int FUNC_BITS   = 2;
   localparam int KEY_BITS    = 64;
   localparam int NODE_BITS   = 8;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // func codes
   localparam logic [FUNC_BITS-1:0] FN_LOOKUP = 2'd0;
   localparam logic [FUNC_BITS-1:0] FN_ADD    = 2'd1;
   localparam logic [FUNC_BITS-1:0] FN_REMOVE = 2'd2;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd3;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [KEY_BITS-1:0]  ring_key;
      logic [NODE_BITS-1:0] node_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [NODE_BITS-1:0]   owner_node;
      logic [COUNT_BITS-1:0]  removed_count;
   } rsp_type;

   // one stored ring position
   typedef struct packed {
      logic [KEY_BITS-1:0]     position;
      logic [NODE_ID_BITS-1:0] owner;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

`default_nettype wire

@@ rtl/core/consistent_hash_ring_table.sv @@
// ----------------------------------------------------------------------------
// Consistent hash ring table
// Ring positions (64-bit key, owner node) with lookup, add and remove items.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   req     | req_valid, req_ready, req_data | func, ring_key, node_id
//   rsp     | rsp_valid, rsp_ready, rsp_data | status, owner_node, removed_count
//
// Every item passes through an accept state, a sweep that issues one RAM read
// per entry, a tail state in which the last read lands, and a finish state.
// The entry RAM has a single read port, and each item sweeps it in full.
// Reset clears the valid bits, the sequencer and the result valid flag; the RAM
// itself is not cleared, invalid entries are never looked at.
// A stalled rsp holds the finished item in the finish state; a new req item is
// taken as soon as the result register has been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring_table
   import chrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,  // waiting for an item
      S_SCAN = 4'b0010,  // issuing one RAM read per entry
      S_TAIL = 4'b0100,  // last read data being checked
      S_DONE = 4'b1000   // write back and load result
   } state_type;

   state_type state_ff, state_in;

   // captured item
   logic [FUNC_BITS-1:0]    op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [NODE_ID_BITS-1:0] node_ff, node_in;

   // sweep address and check stage
   logic [IDX_BITS-1:0] addr_ff, addr_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0] chk_idx_ff, chk_idx_in;

   // lookup accumulators: smallest key and smallest key above the hash
   logic                    any_ff, any_in;
   logic [KEY_BITS-1:0]     min_key_ff, min_key_in;
   logic [NODE_ID_BITS-1:0] min_own_ff, min_own_in;
   logic                    succ_ff, succ_in;
   logic [KEY_BITS-1:0]     succ_key_ff, succ_key_in;
   logic [NODE_ID_BITS-1:0] succ_own_ff, succ_own_in;

   // add: duplicate key slot and first free slot
   logic                hit_ff, hit_in;
   logic [IDX_BITS-1:0] hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [IDX_BITS-1:0] free_idx_ff, free_idx_in;

   // remove: cleared entries
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // RAM side
   logic                  ram_wr_en;
   logic [IDX_BITS-1:0]   ram_wr_addr;
   entry_type             wr_entry;
   logic                  ram_rd_en;
   logic [ENTRY_BITS-1:0] ram_rd_data;
   entry_type             rd_entry;
   logic                  live;

   chrt_entry_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_BITS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);
   assign live     = chk_vld_ff && valid_ff[chk_idx_ff];

   // duplicate keys overwrite with the same key, so one write serves both cases
   assign wr_entry.position = key_ff;
   assign wr_entry.owner    = node_ff;
   assign ram_wr_addr       = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      node_in      = node_ff;
      addr_in      = addr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = addr_ff;
      any_in       = any_ff;
      min_key_in   = min_key_ff;
      min_own_in   = min_own_ff;
      succ_in      = succ_ff;
      succ_key_in  = succ_key_ff;
      succ_own_in  = succ_own_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;

      // check stage: RAM data for entry chk_idx_ff is here
      if (chk_vld_ff) begin
         unique case (op_ff)
            FN_LOOKUP: begin
               if (live && (!any_ff || rd_entry.position < min_key_ff)) begin
                  any_in     = 1'b1;
                  min_key_in = rd_entry.position;
                  min_own_in = rd_entry.owner;
               end
               if (live && rd_entry.position > key_ff &&
                   (!succ_ff || rd_entry.position < succ_key_ff)) begin
                  succ_in     = 1'b1;
                  succ_key_in = rd_entry.position;
                  succ_own_in = rd_entry.owner;
               end
            end
            FN_ADD: begin
               if (live && rd_entry.position == key_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
               end
               if (!valid_ff[chk_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
            FN_REMOVE: begin
               if (live && rd_entry.owner == node_ff) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  cnt_in               = cnt_ff + CNT_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.func;
               key_in   = req_data.ring_key;
               node_in  = req_data.node_id[NODE_ID_BITS-1:0];
               addr_in  = '0;
               any_in   = 1'b0;
               succ_in  = 1'b0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ram_rd_en  = 1'b1;
            chk_vld_in = 1'b1;
            chk_idx_in = addr_ff;
            addr_in    = addr_ff + IDX_BITS'(1);
            if (addr_ff == IDX_BITS'(TABLE_DEPTH - 1)) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = ST_OK;
               rsp_data_in.owner_node    = '0;
               rsp_data_in.removed_count = '0;
               unique case (op_ff)
                  FN_LOOKUP: begin
                     if (!any_ff) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        // wrap to the smallest key when nothing lies above
                        rsp_data_in.owner_node =
                           NODE_BITS'(succ_ff ? succ_own_ff : min_own_ff);
                     end
                  end
                  FN_ADD: begin
                     if (hit_ff) begin
                        ram_wr_en = 1'b1;
                     end else if (free_ff) begin
                        ram_wr_en             = 1'b1;
                        valid_in[free_idx_ff] = 1'b1;
                     end else begin
                        rsp_data_in.status = ST_FULL;
                     end
                  end
                  FN_REMOVE: begin
                     if (cnt_ff == '0) begin
                        rsp_data_in.status = ST_ABSENT;
                     end else if (32'(cnt_ff) > 32'(COUNT_MAX)) begin
                        rsp_data_in.removed_count = COUNT_MAX;
                     end else begin
                        rsp_data_in.removed_count = COUNT_BITS'(cnt_ff);
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and accumulators
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      node_ff     <= node_in;
      addr_ff     <= addr_in;
      chk_idx_ff  <= chk_idx_in;
      any_ff      <= any_in;
      min_key_ff  <= min_key_in;
      min_own_ff  <= min_own_in;
      succ_ff     <= succ_in;
      succ_key_ff <= succ_key_in;
      succ_own_ff <= succ_own_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/chrt_entry_ram.sv @@
// ----------------------------------------------------------------------------
// Ring table entry RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chrt_entry_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/chrt_checker.sv @@
// ----------------------------------------------------------------------------
// Consistent hash ring table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "consistent_hash_ring_table_macros.svh"

module chrt_checker
   import chrt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a waiting result stays put
   `CHRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // only a successful remove reports a count, and it never names an owner
   `CHRT_ASSERT_IMPLY(a_count_ok, clock, reset, rsp_valid && rsp_data.removed_count != '0, rsp_data.status == ST_OK && rsp_data.owner_node == '0)

   // no more entries can be cleared than the table holds
   `CHRT_ASSERT_IMPLY(a_count_max, clock, reset, rsp_valid, 32'(rsp_data.removed_count) <= TABLE_DEPTH)

   // reset leaves no result behind and the block ready for an item
   `CHRT_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid && req_ready)

endmodule

bind consistent_hash_ring_table chrt_checker u_chrt_checker (.*);

`default_nettype wire

@@ tb/tb_consistent_hash_ring_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consistent hash ring table testbench
// Drives lookup, add and remove items through the req channel while the rsp
// channel stalls in changing patterns. A local copy of the ring positions
// predicts each result when its item is accepted. Every result is then
// compared field by field, in order, against that prediction.
// ----------------------------------------------------------------------------

module tb_consistent_hash_ring_table;
   import chrt_pkg::*;

   // func value that the block ignores
   localparam logic [FUNC_BITS-1:0] FN_UNUSED = 2'd3;

   localparam logic [KEY_BITS-1:0] KEY_ALL_ONES = {KEY_BITS{1'b1}};
   localparam logic [KEY_BITS-1:0] KEY_TOP_BIT  = {1'b1, {(KEY_BITS-1){1'b0}}};

   localparam int ITEM_CYCLES   = TABLE_DEPTH + 3;   // per-item sweep cost
   localparam int LONG_HOLD     = 6 * ITEM_CYCLES;   // rsp held off this long
   localparam int QUIET_LIMIT   = 4000;              // cycles with no handshake
   localparam int RANDOM_ITEMS  = 170;               // per random test call

   // receiver stall patterns
   typedef enum int {
      RX_OPEN,     // always ready
      RX_COIN,     // ready half the time
      RX_SPARSE,   // ready about one cycle in eight
      RX_BEAT      // two ready cycles out of five
   } rx_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   consistent_hash_ring_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow of the ring: key, owner and in-use flag per slot. Updated when an
   // item is accepted, so it always reflects every item the block has taken.
   // ------------------------------------------------------------------------
   logic [KEY_BITS-1:0]     ring_pos  [TABLE_DEPTH];
   logic [NODE_ID_BITS-1:0] ring_own  [TABLE_DEPTH];
   bit                      ring_used [TABLE_DEPTH];

   rsp_type ring_results_due [$];   // predicted results, oldest first

   int errors      = 0;
   int results_ok  = 0;
   int func_seen [4];
   int full_seen   = 0;
   int empty_seen  = 0;
   int absent_seen = 0;
   int most_removed = 0;

   // Apply one item to the shadow ring and return the result it must give.
   function automatic rsp_type predict_ring_result(input req_type item);
      rsp_type                 res;
      logic [NODE_ID_BITS-1:0] node;
      logic [KEY_BITS-1:0]     min_key, succ_key;
      logic [NODE_ID_BITS-1:0] min_own, succ_own;
      bit                      any_pos, have_succ, dup_hit;
      int                      free_slot, cleared;
      res       = '0;
      res.status = ST_OK;
      node      = item.node_id[NODE_ID_BITS-1:0];   // upper id bits dropped
      min_key   = '0;
      succ_key  = '0;
      min_own   = '0;
      succ_own  = '0;
      any_pos   = 1'b0;
      have_succ = 1'b0;
      dup_hit   = 1'b0;
      free_slot = -1;
      cleared   = 0;
      case (item.func)
         FN_LOOKUP: begin
            // successor strictly above the hash, else wrap to the lowest key
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (ring_used[i]) begin
                  if (!any_pos || ring_pos[i] < min_key) begin
                     min_key = ring_pos[i];
                     min_own = ring_own[i];
                     any_pos = 1'b1;
                  end
                  if (ring_pos[i] > item.ring_key &&
                      (!have_succ || ring_pos[i] < succ_key)) begin
                     succ_key  = ring_pos[i];
                     succ_own  = ring_own[i];
                     have_succ = 1'b1;
                  end
               end
            end
            if (!any_pos)
               res.status = ST_EMPTY;
            else
               res.owner_node = NODE_BITS'(have_succ ? succ_own : min_own);
         end
         FN_ADD: begin
            // existing key: new owner; else lowest free slot; else full
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (ring_used[i]) begin
                  if (ring_pos[i] == item.ring_key) begin
                     ring_own[i] = node;
                     dup_hit     = 1'b1;
                  end
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (!dup_hit) begin
               if (free_slot < 0) begin
                  res.status = ST_FULL;
               end else begin
                  ring_pos[free_slot]  = item.ring_key;
                  ring_own[free_slot]  = node;
                  ring_used[free_slot] = 1'b1;
               end
            end
         end
         FN_REMOVE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (ring_used[i] && ring_own[i] == node) begin
                  ring_used[i] = 1'b0;
                  cleared++;
               end
            end
            if (cleared == 0)
               res.status = ST_ABSENT;
            else
               res.removed_count = (cleared > int'(COUNT_MAX)) ? COUNT_MAX
                                                               : cleared[COUNT_BITS-1:0];
         end
         default: ;   // unused func: no state change, all-zero result
      endcase
      return res;
   endfunction

   function automatic int ring_fill();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         n += int'(ring_used[i]);
      return n;
   endfunction

   // random in-use slot, or -1 on an empty ring
   function automatic int pick_used_slot();
      int slots [$];
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (ring_used[i])
            slots.insert(slots.size(), i);
      if (slots.size() == 0)
         return -1;
      return slots[$urandom_range(0, slots.size() - 1)];
   endfunction

   function automatic logic [KEY_BITS-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // mostly a handful of nodes so removes clear several slots
   function automatic logic [NODE_BITS-1:0] random_node();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return NODE_BITS'($urandom_range(0, 7));
      if (r < 9)
         return NODE_BITS'($urandom_range(0, 255));
      return $urandom_range(0, 1) ? {NODE_BITS{1'b1}} : {NODE_BITS{1'b0}};
   endfunction

   function automatic req_type make_item(input logic [FUNC_BITS-1:0] func,
                                         input logic [KEY_BITS-1:0]  key,
                                         input logic [NODE_BITS-1:0] node);
      req_type item;
      item.func     = func;
      item.ring_key = key;
      item.node_id  = node;
      return item;
   endfunction

   // Random item; a growing ring favors adds, a shrinking one removes.
   function automatic req_type random_ring_item(input bit growing);
      int                  r, k, slot;
      logic [KEY_BITS-1:0] key;
      r    = $urandom_range(0, 99);
      k    = $urandom_range(0, 9);
      slot = pick_used_slot();
      if ((growing && r < 60) || (!growing && r >= 45 && r < 63)) begin
         if (k < 7 || slot < 0)
            key = random_key();
         else if (k < 9)
            key = ring_pos[slot];                     // duplicate key
         else
            case ($urandom_range(0, 3))
               0:       key = '0;
               1:       key = KEY_ALL_ONES;
               2:       key = KEY_TOP_BIT;
               default: key = KEY_BITS'($urandom_range(0, 15));
            endcase
         return make_item(FN_ADD, key, random_node());
      end
      if ((growing && r < 90) || (!growing && r < 45)) begin
         // lookups land on, just below and just above stored keys
         if (slot < 0 || k >= 5)
            key = (k == 8) ? '0 : (k == 9) ? KEY_ALL_ONES : random_key();
         else if (k < 3)
            key = ring_pos[slot];
         else if (k == 3)
            key = ring_pos[slot] - KEY_BITS'(1);
         else
            key = ring_pos[slot] + KEY_BITS'(1);
         return make_item(FN_LOOKUP, key, NODE_BITS'($urandom_range(0, 255)));
      end
      if ((growing && r < 96) || (!growing && r < 95)) begin
         if (slot >= 0 && k < 7)
            return make_item(FN_REMOVE, random_key(), ring_own[slot]);
         return make_item(FN_REMOVE, random_key(), random_node());
      end
      return make_item(FN_UNUSED, random_key(), NODE_BITS'($urandom_range(0, 255)));
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Valid stays high across back-to-back items; only a gap or a drain
   // lowers it. The prediction is taken at the edge where the item is accepted.
   // ------------------------------------------------------------------------
   task automatic send_item(input req_type item);
      rsp_type res;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      res = predict_ring_result(item);
      ring_results_due.insert(ring_results_due.size(), res);
      func_seen[item.func]++;
      if (item.func == FN_ADD && res.status == ST_FULL)
         full_seen++;
      if (res.status == ST_EMPTY)
         empty_seen++;
      if (res.status == ST_ABSENT)
         absent_seen++;
      if (int'(res.removed_count) > most_removed)
         most_removed = int'(res.removed_count);
   endtask

   task automatic sender_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles)
         @(posedge clock);
   endtask

   // random gap or none, so idle cycles hit every point of the item sweep
   task automatic maybe_gap();
      if ($urandom_range(0, 3) != 0)
         sender_gap($urandom_range(1, 90));
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (ring_results_due.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver. Switches stall pattern when the rx_left countdown runs out; on
   // request it holds rsp_ready low until hold_left runs out, so the block backs up.
   // ------------------------------------------------------------------------
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 200;
   int          rx_phase = 0;
   int          hold_left = 0;
   int          hold_req_count = 0;
   int          hold_seen_count = 0;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req_count != hold_seen_count) begin
         rsp_ready       <= 1'b0;
         hold_left       <= LONG_HOLD - 1;
         hold_seen_count <= hold_req_count;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
            default:   rsp_ready <= (rx_phase % 5) < 2;
         endcase
         rx_phase <= rx_phase + 1;
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(50, 400);
         end else begin
            rx_left <= rx_left - 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: each accepted result against the oldest prediction.
   // ------------------------------------------------------------------------
   rsp_type want_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (ring_results_due.size() == 0) begin
            $error("result with nothing outstanding: status %0d owner %0d count %0d",
                   rsp_data.status, rsp_data.owner_node, rsp_data.removed_count);
            errors++;
         end else begin
            want_rsp = ring_results_due.pop_front();
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.owner_node !== want_rsp.owner_node) begin
               $error("owner_node: expected %0d, got %0d",
                      want_rsp.owner_node, rsp_data.owner_node);
               errors++;
            end
            if (rsp_data.removed_count !== want_rsp.removed_count) begin
               $error("removed_count: expected %0d, got %0d",
                      want_rsp.removed_count, rsp_data.removed_count);
               errors++;
            end
            results_ok++;
         end
      end
   end

   // Watchdog: too long without a handshake on either channel ends the run.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, ring_results_due.size());
         $display("tb_consistent_hash_ring_table: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // lookups and a remove on an empty ring, plus an ignored func value
   task automatic test_empty_ring();
      send_item(make_item(FN_LOOKUP, '0, 8'd0));
      send_item(make_item(FN_LOOKUP, KEY_ALL_ONES, 8'hFF));
      send_item(make_item(FN_REMOVE, KEY_ALL_ONES, 8'd0));
      send_item(make_item(FN_UNUSED, KEY_ALL_ONES, 8'hFF));
   endtask

   // successor, equal-key, wraparound, duplicate add and remove behavior
   task automatic test_ring_basics();
      send_item(make_item(FN_ADD, 64'd100, 8'd1));
      send_item(make_item(FN_ADD, KEY_ALL_ONES, 8'hFF));
      send_item(make_item(FN_ADD, '0, 8'd0));
      send_item(make_item(FN_LOOKUP, 64'd99, 8'd0));        // next key up
      send_item(make_item(FN_LOOKUP, 64'd100, 8'd0));       // equal is skipped
      send_item(make_item(FN_LOOKUP, KEY_ALL_ONES, 8'd0));  // wraps to key zero
      send_item(make_item(FN_LOOKUP, '0, 8'd0));
      send_item(make_item(FN_ADD, 64'd100, 8'd7));          // duplicate: new owner
      send_item(make_item(FN_LOOKUP, 64'd50, 8'd0));
      send_item(make_item(FN_ADD, KEY_TOP_BIT, 8'd7));
      send_item(make_item(FN_LOOKUP, 64'd150, 8'd0));
      send_item(make_item(FN_REMOVE, '0, 8'd7));            // clears two slots
      send_item(make_item(FN_REMOVE, '0, 8'd7));            // now absent
      send_item(make_item(FN_UNUSED, '0, 8'd0));
      send_item(make_item(FN_LOOKUP, 64'd150, 8'd0));
      send_item(make_item(FN_REMOVE, KEY_ALL_ONES, 8'hFF));
      send_item(make_item(FN_REMOVE, '0, 8'd0));
      send_item(make_item(FN_LOOKUP, 64'd5, 8'd0));         // empty again
   endtask

   // empty the ring, fill every slot for one node, overflow it, remove all
   task automatic test_full_ring();
      logic [NODE_BITS-1:0] node;
      int                   slot;
      while (ring_fill() != 0) begin
         send_item(make_item(FN_REMOVE, random_key(), ring_own[pick_used_slot()]));
         maybe_gap();
      end
      node = NODE_BITS'($urandom_range(0, 255));
      while (ring_fill() < TABLE_DEPTH) begin
         send_item(make_item(FN_ADD, random_key(), node));
         if ($urandom_range(0, 5) == 0)
            maybe_gap();
      end
      send_item(make_item(FN_ADD, random_key(), node));      // table full
      send_item(make_item(FN_ADD, random_key(), ~node));     // table full
      slot = pick_used_slot();
      send_item(make_item(FN_ADD, ring_pos[slot], node));    // duplicate while full
      send_item(make_item(FN_LOOKUP, ring_pos[slot], 8'd0));
      send_item(make_item(FN_LOOKUP, KEY_ALL_ONES, 8'd0));
      send_item(make_item(FN_REMOVE, '0, node));             // every slot at once
      send_item(make_item(FN_LOOKUP, random_key(), 8'd0));
   endtask

   // bursts of random items; the ring grows toward full, then shrinks
   task automatic test_random_ring(input int count);
      bit growing;
      int sent, burst, fill;
      growing = 1'b1;
      sent    = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst && sent < count; b++) begin
            fill = ring_fill();
            if (fill == TABLE_DEPTH && $urandom_range(0, 3) == 0)
               growing = 1'b0;
            else if (fill <= 2)
               growing = 1'b1;
            send_item(random_ring_item(growing));
            sent++;
         end
         maybe_gap();
      end
   endtask

   // rsp held off while items keep coming, so req_ready must drop; then the
   // sender waits for every outstanding result before moving on
   task automatic test_backpressure();
      hold_req_count <= hold_req_count + 1;
      for (int i = 0; i < 12; i++)
         send_item(random_ring_item(ring_fill() < TABLE_DEPTH / 2));
      wait_results_drained();
   endtask

   initial begin
      repeat (7)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_ring();
      test_ring_basics();
      test_full_ring();
      test_random_ring(RANDOM_ITEMS);
      test_backpressure();
      test_random_ring(RANDOM_ITEMS);

      wait_results_drained();
      // an item that went astray would surface during this final wait
      repeat (ITEM_CYCLES + 8)
         @(posedge clock);

      $display("covered %0d lookups, %0d adds, %0d removes, %0d ignored items; %0d results",
               func_seen[FN_LOOKUP], func_seen[FN_ADD], func_seen[FN_REMOVE],
               func_seen[FN_UNUSED], results_ok);
      $display("full-table adds %0d, empty lookups %0d, absent removes %0d, max removed %0d",
               full_seen, empty_seen, absent_seen, most_removed);
      if (errors == 0)
         $display("tb_consistent_hash_ring_table: clean");
      else
         $display("tb_consistent_hash_ring_table: errors");
      $finish;
   end

endmodule
